// ===== design/ped_pkg.sv =====
// pointer event decoder: shared types, event codes and helper functions
// used by every module of the block; depends on nothing else
package ped_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int SUM_W  = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 2;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int MAG_W  = (DIFF_W > 32) ? 32 : DIFF_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int CMP_W  = (D2_W > 32) ? D2_W : 32;
  localparam int REP_W  = 17;
  localparam int WHEEL_W = 39;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] TYPE_SYN = 16'd0;
  localparam logic [15:0] TYPE_KEY = 16'd1;
  localparam logic [15:0] TYPE_REL = 16'd2;
  localparam logic [15:0] TYPE_ABS = 16'd3;

  localparam logic [15:0] CODE_X      = 16'd0;
  localparam logic [15:0] CODE_Y      = 16'd1;
  localparam logic [15:0] CODE_HWHEEL = 16'd6;
  localparam logic [15:0] CODE_WHEEL  = 16'd8;
  localparam logic [15:0] KEY_LEFT    = 16'h0110;
  localparam logic [15:0] KEY_RIGHT   = 16'h0111;
  localparam logic [15:0] KEY_MIDDLE  = 16'h0112;
  localparam logic [15:0] KEY_TOUCH   = 16'h014a;
  localparam logic [15:0] SYNC_REPORT = 16'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 2'd3;

  localparam logic KIND_MOUSE = 1'b0;
  localparam logic KIND_WHEEL = 1'b1;

  localparam logic [2:0] HELD_NONE   = 3'b000;
  localparam logic [2:0] HELD_LEFT   = 3'b001;
  localparam logic [2:0] HELD_RIGHT  = 3'b010;
  localparam logic [2:0] HELD_MIDDLE = 3'b100;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic               compression_on;
    logic [31:0]        jitter_limit_sq;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic               batch_end;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } item_t;

  typedef struct packed {
    logic                       kind;
    logic [REP_W-1:0]           report_x;
    logic [REP_W-1:0]           report_y;
    logic [2:0]                 button_mask;
    logic [WHEEL_W-1:0]         wheel_delta;
    logic                       wheel_horizontal;
  } result_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return coord_t'(hi);
    end else if (v < lo) begin
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

  function automatic logic [MAG_W-1:0] clamp_mag(input logic [DIFF_W-1:0] a);
    if (64'(a) > 64'h8000_0000) begin
      return MAG_W'(64'h8000_0000);
    end
    return MAG_W'(a);
  endfunction

endpackage

// ===== design/pointer_event_decoder.sv =====
// pointer event decoder top level: input register, decode and result register
// depends on ped_pkg, ped_cfg_regs, ped_in_stage, ped_decode, ped_out_stage
//
//   port group  dir  contents
//   in_*        in   event transaction, tlast marks end of read batch
//   out_*       out  mouse or wheel report transaction
//   cfg_*       in   register writes, index 0..3, no read-back
//
// one event per cycle unless a reporting event meets a stalled result register;
// an event's decode and state update happen on the way from input to result register
// events that give no report retire even while the result register is stalled
// reset (rst_n low at a clock edge) clears state and configuration to defaults
module pointer_event_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] event_type, [31:16] event_code, [63:32] event_value
  input  logic [ped_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] report_x, [33:17] report_y, [36:34] button_mask,
  // [75:37] wheel_delta, [79:76] zero
  output logic [ped_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] result_kind, [1] wheel_horizontal
  output logic [ped_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                               cfg_we,
  input  logic [ped_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ped_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ped_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    has_result;
  logic    out_free;
  logic    advance;

  assign advance = item_valid && (!has_result || out_free);

  ped_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ped_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .pop        (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ped_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item       (item),
    .advance    (advance),
    .has_result (has_result),
    .result     (result)
  );

  ped_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && has_result),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== design/ped_cfg_regs.sv =====
// configuration registers of the pointer event decoder
// depends on ped_pkg
module ped_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ped_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ped_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ped_pkg::cfg_t                     cfg
);
  import ped_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compression_on  <= 1'b1;
      cfg_r.jitter_limit_sq <= '0;
      cfg_r.offset_x        <= '0;
      cfg_r.offset_y        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPRESSION: cfg_r.compression_on  <= cfg_wdata[0];
        CFG_JITTER:      cfg_r.jitter_limit_sq <= cfg_wdata[31:0];
        CFG_OFFSET_X:    cfg_r.offset_x        <= cfg_wdata[15:0];
        CFG_OFFSET_Y:    cfg_r.offset_y        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/ped_in_stage.sv =====
// input register of the pointer event decoder: holds one event transaction
// depends on ped_pkg
module ped_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ped_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  input  logic                              pop,
  output logic                              item_valid,
  output ped_pkg::item_t                    item
);
  import ped_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready = !valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.batch_end <= in_tlast;
      item_r.ev_type   <= in_tdata[15:0];
      item_r.ev_code   <= in_tdata[31:16];
      item_r.ev_value  <= in_tdata[63:32];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/ped_decode.sv =====
// event decode, pointer state and report building of the pointer event decoder
// depends on ped_pkg
module ped_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  ped_pkg::cfg_t    cfg,
  input  ped_pkg::item_t   item,
  input  logic             advance,
  output logic             has_result,
  output ped_pkg::result_t result
);
  import ped_pkg::*;

  coord_t     pointer_x_r, pointer_x_nxt;
  coord_t     pointer_y_r, pointer_y_nxt;
  coord_t     last_x_r, last_x_nxt;
  coord_t     last_y_r, last_y_nxt;
  logic [2:0] buttons_r, buttons_nxt;
  logic       moved_r, moved_nxt;
  logic       pending_r, pending_nxt;

  logic signed [SUM_W-1:0]   value_ext;
  logic signed [SUM_W-1:0]   rel_sum_x, rel_sum_y;
  logic signed [SUM_W-1:0]   mouse_x, mouse_y;
  logic signed [SUM_W-1:0]   raw_x, raw_y;
  coord_t                    abs_val;
  logic signed [DIFF_W-1:0]  diff_x, diff_y;
  logic [DIFF_W-1:0]         abs_x, abs_y;
  logic [MAG_W-1:0]          mag_x, mag_y;
  logic [SQ_W-1:0]           sq_x, sq_y;
  logic [CMP_W-1:0]          dist_sq;
  logic signed [WHEEL_W-1:0] value_w, wheel_step;
  logic                      send_mouse;
  logic [2:0]                key_bit;

  assign value_ext = SUM_W'(item.ev_value);
  assign rel_sum_x = SUM_W'(pointer_x_r) + value_ext;
  assign rel_sum_y = SUM_W'(pointer_y_r) + value_ext;
  assign abs_val   = sat_coord(value_ext);
  assign mouse_x   = SUM_W'(pointer_x_r) + SUM_W'(cfg.offset_x);
  assign mouse_y   = SUM_W'(pointer_y_r) + SUM_W'(cfg.offset_y);
  assign raw_x     = SUM_W'(pointer_x_r);
  assign raw_y     = SUM_W'(pointer_y_r);

  assign diff_x  = DIFF_W'(pointer_x_r) - DIFF_W'(last_x_r);
  assign diff_y  = DIFF_W'(pointer_y_r) - DIFF_W'(last_y_r);
  assign abs_x   = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
  assign abs_y   = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
  assign mag_x   = clamp_mag(abs_x);
  assign mag_y   = clamp_mag(abs_y);
  assign sq_x    = SQ_W'(mag_x) * SQ_W'(mag_x);
  assign sq_y    = SQ_W'(mag_y) * SQ_W'(mag_y);
  assign dist_sq = CMP_W'(sq_x) + CMP_W'(sq_y);

  // 120 * value as shift and subtract
  assign value_w    = WHEEL_W'(item.ev_value);
  assign wheel_step = (value_w <<< 7) - (value_w <<< 3);

  always_comb begin
    unique case (item.ev_code)
      KEY_LEFT:  key_bit = HELD_LEFT;
      KEY_RIGHT: key_bit = HELD_RIGHT;
      default:   key_bit = HELD_MIDDLE;
    endcase
  end

  always_comb begin
    pointer_x_nxt = pointer_x_r;
    pointer_y_nxt = pointer_y_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    buttons_nxt   = buttons_r;
    moved_nxt     = moved_r;
    pending_nxt   = pending_r;
    send_mouse    = 1'b0;
    has_result    = 1'b0;
    result        = '0;

    priority if (item.batch_end) begin
      if (cfg.compression_on && pending_r &&
          (dist_sq > CMP_W'(cfg.jitter_limit_sq))) begin
        send_mouse = 1'b1;
      end
      moved_nxt   = 1'b0;
      pending_nxt = 1'b0;
    end else if (item.ev_type == TYPE_ABS) begin
      if (item.ev_code == CODE_X && pointer_x_r != abs_val) begin
        pointer_x_nxt = abs_val;
        moved_nxt     = 1'b1;
      end else if (item.ev_code == CODE_Y && pointer_y_r != abs_val) begin
        pointer_y_nxt = abs_val;
        moved_nxt     = 1'b1;
      end
    end else if (item.ev_type == TYPE_REL) begin
      priority if (item.ev_code == CODE_X) begin
        pointer_x_nxt = sat_coord(rel_sum_x);
        moved_nxt     = 1'b1;
      end else if (item.ev_code == CODE_Y) begin
        pointer_y_nxt = sat_coord(rel_sum_y);
        moved_nxt     = 1'b1;
      end else if (item.ev_code == CODE_WHEEL || item.ev_code == CODE_HWHEEL) begin
        has_result              = 1'b1;
        result.kind             = KIND_WHEEL;
        result.report_x         = raw_x[REP_W-1:0];
        result.report_y         = raw_y[REP_W-1:0];
        result.button_mask      = HELD_NONE;
        result.wheel_horizontal = (item.ev_code == CODE_HWHEEL);
        result.wheel_delta      = (item.ev_code == CODE_HWHEEL) ?
                                  WHEEL_W'(-wheel_step) : WHEEL_W'(wheel_step);
      end else begin
      end
    end else if (item.ev_type == TYPE_KEY && item.ev_code == KEY_TOUCH) begin
      buttons_nxt = (item.ev_value != 32'sd0) ? HELD_LEFT : HELD_NONE;
      pending_nxt = 1'b0;
      send_mouse  = 1'b1;
    end else if (item.ev_type == TYPE_KEY && item.ev_code >= KEY_LEFT &&
                 item.ev_code <= KEY_MIDDLE) begin
      buttons_nxt = (item.ev_value != 32'sd0) ? (buttons_r | key_bit)
                                              : (buttons_r & ~key_bit);
      pending_nxt = 1'b0;
      send_mouse  = 1'b1;
    end else if (item.ev_type == TYPE_SYN && item.ev_code == SYNC_REPORT) begin
      if (moved_r) begin
        moved_nxt = 1'b0;
        if (cfg.compression_on) begin
          pending_nxt = 1'b1;
        end else begin
          send_mouse = 1'b1;
        end
      end
    end else begin
    end

    if (send_mouse) begin
      has_result              = 1'b1;
      result.kind             = KIND_MOUSE;
      result.report_x         = mouse_x[REP_W-1:0];
      result.report_y         = mouse_y[REP_W-1:0];
      result.button_mask      = buttons_nxt;
      result.wheel_delta      = '0;
      result.wheel_horizontal = 1'b0;
      last_x_nxt              = pointer_x_r;
      last_y_nxt              = pointer_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pointer_x_r <= '0;
      pointer_y_r <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      buttons_r   <= '0;
      moved_r     <= 1'b0;
      pending_r   <= 1'b0;
    end else if (advance) begin
      pointer_x_r <= pointer_x_nxt;
      pointer_y_r <= pointer_y_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      buttons_r   <= buttons_nxt;
      moved_r     <= moved_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

// ===== design/ped_out_stage.sv =====
// result register of the pointer event decoder: holds one report transaction
// depends on ped_pkg
module ped_out_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  ped_pkg::result_t                   result,
  output logic                               out_free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ped_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [ped_pkg::OUT_USER_W-1:0]     out_tuser
);
  import ped_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign out_free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, result_r.wheel_delta, result_r.button_mask,
                       result_r.report_y, result_r.report_x};
  assign out_tuser  = {result_r.wheel_horizontal, result_r.kind};

endmodule

// ===== tb/testbench.sv =====
// self-checking bench for pointer_event_decoder: directed events, then random
// input frames and noise under several register settings and handshake pressures
// depends on ped_pkg and the pointer_event_decoder top level
module testbench;
  import ped_pkg::*;

  localparam longint WHEEL_STEP = 120;
  localparam logic [15:0] TYPE_MISC = 16'd4;
  localparam logic [15:0] SYNC_CONFIG = 16'd1;
  localparam logic [15:0] CODE_BOGUS = 16'hffff;
  localparam logic [15:0] KEY_PAST_MIDDLE = KEY_MIDDLE + 16'd1;

  class report_scoreboard;
    typedef struct {
      bit               kind;
      bit [REP_W-1:0]   rx;
      bit [REP_W-1:0]   ry;
      bit [2:0]         buttons;
      bit [WHEEL_W-1:0] delta;
      bit               horizontal;
    } report_t;

    report_t expected_q[$];
    int errors;
    bit compress;
    bit [31:0] jitter_lim;
    longint off_x, off_y;
    longint px, py, sent_x, sent_y;
    bit [2:0] held;
    bit moved, pending;

    function new();
      errors = 0;
      compress = 1'b1;
      jitter_lim = '0;
      off_x = 0;
      off_y = 0;
      px = 0;
      py = 0;
      sent_x = 0;
      sent_y = 0;
      held = HELD_NONE;
      moved = 1'b0;
      pending = 1'b0;
    endfunction

    function bit busy();
      return expected_q.size() != 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_COMPRESSION: compress = val[0];
        CFG_JITTER:      jitter_lim = val;
        CFG_OFFSET_X:    off_x = $signed(val[15:0]);
        CFG_OFFSET_Y:    off_y = $signed(val[15:0]);
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint unsigned span(longint d);
      longint unsigned a;
      a = (d < 0) ? longint'(-d) : longint'(d);
      return (a > 64'h8000_0000) ? 64'h8000_0000 : a;
    endfunction

    function void push_mouse();
      report_t r;
      r.kind = KIND_MOUSE;
      r.rx = REP_W'(px + off_x);
      r.ry = REP_W'(py + off_y);
      r.buttons = held;
      r.delta = '0;
      r.horizontal = 1'b0;
      sent_x = px;
      sent_y = py;
      expected_q.push_back(r);
    endfunction

    function void push_wheel(longint delta, bit horiz);
      report_t r;
      r.kind = KIND_WHEEL;
      r.rx = REP_W'(px);
      r.ry = REP_W'(py);
      r.buttons = HELD_NONE;
      r.delta = WHEEL_W'(delta);
      r.horizontal = horiz;
      expected_q.push_back(r);
    endfunction

    function void note_event(logic last, logic [IN_DATA_W-1:0] data);
      logic [15:0] ty;
      logic [15:0] cd;
      longint val;
      longint v;
      longint unsigned dx, dy;
      bit [2:0] bitsel;
      ty = data[15:0];
      cd = data[31:16];
      val = $signed(data[63:32]);
      if (last) begin
        if (compress && pending) begin
          dx = span(px - sent_x);
          dy = span(py - sent_y);
          if (dx * dx + dy * dy > longint'(jitter_lim)) push_mouse();
        end
        moved = 1'b0;
        pending = 1'b0;
        return;
      end
      if (ty == TYPE_ABS) begin
        v = clip(val);
        if (cd == CODE_X && px != v) begin
          px = v;
          moved = 1'b1;
        end else if (cd == CODE_Y && py != v) begin
          py = v;
          moved = 1'b1;
        end
      end else if (ty == TYPE_REL) begin
        if (cd == CODE_X) begin
          px = clip(px + val);
          moved = 1'b1;
        end else if (cd == CODE_Y) begin
          py = clip(py + val);
          moved = 1'b1;
        end else if (cd == CODE_WHEEL) begin
          push_wheel(WHEEL_STEP * val, 1'b0);
        end else if (cd == CODE_HWHEEL) begin
          push_wheel(-(WHEEL_STEP * val), 1'b1);
        end
      end else if (ty == TYPE_KEY && cd == KEY_TOUCH) begin
        held = (val != 0) ? HELD_LEFT : HELD_NONE;
        pending = 1'b0;
        push_mouse();
      end else if (ty == TYPE_KEY && cd >= KEY_LEFT && cd <= KEY_MIDDLE) begin
        bitsel = (cd == KEY_LEFT) ? HELD_LEFT : (cd == KEY_RIGHT) ? HELD_RIGHT : HELD_MIDDLE;
        held = (val != 0) ? (held | bitsel) : (held & ~bitsel);
        pending = 1'b0;
        push_mouse();
      end else if (ty == TYPE_SYN && cd == SYNC_REPORT) begin
        if (moved) begin
          moved = 1'b0;
          if (compress) pending = 1'b1;
          else push_mouse();
        end
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
      if (act !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] td, logic [OUT_USER_W-1:0] tu);
      report_t e;
      if (expected_q.size() == 0) begin
        $error("report with none expected: tdata %0h tuser %0h", td, tu);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("result_kind", 64'(e.kind), 64'(tu[0]));
      compare_field("report_x", 64'(e.rx), 64'(td[16:0]));
      compare_field("report_y", 64'(e.ry), 64'(td[33:17]));
      compare_field("button_mask", 64'(e.buttons), 64'(td[36:34]));
      compare_field("wheel_delta", 64'(e.delta), 64'(td[75:37]));
      compare_field("wheel_horizontal", 64'(e.horizontal), 64'(tu[1]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  wire in_tready;
  wire out_tvalid;
  wire [OUT_DATA_W-1:0] out_tdata;
  wire [OUT_USER_W-1:0] out_tuser;

  report_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;

  pointer_event_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

  // transaction monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_event(in_tlast, in_tdata);
      if (out_tvalid && out_tready) sb.check_report(out_tdata, out_tuser);
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_event(input logic last, input logic [15:0] ty, input logic [15:0] cd,
                            input logic [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tlast <= last;
    in_tdata <= {val, cd, ty};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic end_batch();
    send_event(1'b1, 16'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.busy()) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // upper bits of the narrow registers carry junk
  task automatic program_regs(input bit comp, input logic [31:0] jit,
                              input logic [15:0] ox, input logic [15:0] oy);
    reg_write(CFG_COMPRESSION, {31'($urandom), comp});
    reg_write(CFG_JITTER, jit);
    reg_write(CFG_OFFSET_X, {16'($urandom), ox});
    reg_write(CFG_OFFSET_Y, {16'($urandom), oy});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 80000)) - 40000);
      default: return 32'(int'($urandom_range(0, 60)) - 30);
    endcase
  endfunction

  function automatic logic [31:0] pick_abs(input longint centre);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sd32767;
          1: return -32'sd32768;
          2: return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      2: return 32'($signed(16'($urandom)));
      default: return 32'(centre + longint'($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  task automatic random_frame();
    int n;
    logic [15:0] cd;
    logic [31:0] val;
    n = $urandom_range(1, 4);
    repeat (n) begin
      cd = $urandom_range(0, 1) ? CODE_Y : CODE_X;
      if ($urandom_range(0, 2) == 0) begin
        send_event(1'b0, TYPE_REL, cd, pick_delta());
      end else begin
        send_event(1'b0, TYPE_ABS, cd, pick_abs((cd == CODE_X) ? sb.px : sb.py));
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: cd = KEY_LEFT;
        1: cd = KEY_RIGHT;
        2: cd = KEY_MIDDLE;
        default: cd = KEY_TOUCH;
      endcase
      case ($urandom_range(0, 2))
        0: val = '0;
        1: val = 32'd1;
        default: val = $urandom;
      endcase
      send_event(1'b0, TYPE_KEY, cd, val);
    end
    if ($urandom_range(0, 6) == 0) begin
      send_event(1'b0, TYPE_REL, $urandom_range(0, 1) ? CODE_WHEEL : CODE_HWHEEL,
                 $urandom_range(0, 3) == 0 ? $urandom : pick_delta());
    end
    send_event(1'b0, TYPE_SYN, SYNC_REPORT, $urandom);
    if ($urandom_range(0, 2) == 0) end_batch();
  endtask

  task automatic send_noise();
    logic [15:0] ty;
    logic [15:0] cd;
    ty = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4));
    case ($urandom_range(0, 7))
      0: cd = CODE_X;
      1: cd = CODE_Y;
      2: cd = CODE_WHEEL;
      3: cd = CODE_HWHEEL;
      4: cd = 16'($urandom_range(KEY_LEFT, KEY_PAST_MIDDLE));
      5: cd = KEY_TOUCH;
      6: cd = SYNC_CONFIG;
      default: cd = 16'($urandom);
    endcase
    send_event($urandom_range(0, 9) == 0, ty, cd, $urandom);
  endtask

  initial begin
    int target;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings
    send_event(1'b0, TYPE_ABS, CODE_X, 32'h7fff_ffff);
    send_event(1'b0, TYPE_ABS, CODE_Y, 32'h8000_0000);
    send_event(1'b0, TYPE_ABS, CODE_X, 32'sd32767);
    send_event(1'b0, TYPE_SYN, SYNC_REPORT, '0);
    end_batch();
    send_event(1'b0, TYPE_REL, CODE_X, -32'sd5);
    send_event(1'b0, TYPE_REL, CODE_Y, 32'h8000_0000);
    send_event(1'b0, TYPE_REL, CODE_X, 32'h7fff_ffff);
    send_event(1'b0, TYPE_SYN, SYNC_CONFIG, '0);
    send_event(1'b0, TYPE_SYN, SYNC_REPORT, '0);
    send_event(1'b0, TYPE_KEY, KEY_LEFT, 32'd1);
    end_batch();
    send_event(1'b0, TYPE_KEY, KEY_RIGHT, 32'd1);
    send_event(1'b0, TYPE_KEY, KEY_MIDDLE, 32'd5);
    send_event(1'b0, TYPE_KEY, KEY_LEFT, '0);
    send_event(1'b0, TYPE_KEY, KEY_TOUCH, 32'd7);
    send_event(1'b0, TYPE_KEY, KEY_TOUCH, '0);
    send_event(1'b0, TYPE_REL, CODE_WHEEL, 32'h7fff_ffff);
    send_event(1'b0, TYPE_REL, CODE_WHEEL, 32'h8000_0000);
    send_event(1'b0, TYPE_REL, CODE_HWHEEL, -32'sd3);
    send_event(1'b0, TYPE_REL, CODE_HWHEEL, 32'h8000_0000);
    send_event(1'b0, TYPE_MISC, CODE_X, 32'd1);
    send_event(1'b0, CODE_BOGUS, CODE_BOGUS, 32'hffff_ffff);
    send_event(1'b0, TYPE_REL, CODE_BOGUS, 32'd9);
    send_event(1'b0, TYPE_KEY, KEY_PAST_MIDDLE, 32'd1);
    end_batch();
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(1'b0, '0, 16'h7fff, 16'h8000);
        1: program_regs(1'b1, 32'd4294836225, 16'h8000, 16'h7fff);
        2: program_regs(1'b1, 32'd25, 16'($urandom), 16'($urandom));
        3: program_regs(1'b1, $urandom_range(0, 400), '0, 16'($urandom));
        4: program_regs(1'b0, $urandom, 16'($urandom), 16'($urandom));
        5: program_regs(1'b1, '0, '0, '0);
        6: program_regs(1'b1, $urandom_range(0, 10000), 16'($urandom), 16'($urandom));
        default: program_regs(1'b1, 32'd1, 16'($urandom), '0);
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      target = sent_items + 220;
      while (sent_items < target) begin
        if ($urandom_range(0, 99) < 75) random_frame();
        else send_noise();
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (sb.errors == 0 && !sb.busy()) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
